[sv/mcsf_pkg.sv]
`timescale 1ns / 1ps

package mcsf_pkg;

  // radius is clamped to this value
  localparam logic [4:0] MAX_RADIUS = 5'd20;
  // spans per point and walk limit in points (64 spans)
  localparam int SPANS_PER_POINT = 4;
  localparam logic [3:0] LAST_POINT_IDX = 4'd15;
  // point queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // one walk point handed from front to back
  typedef struct packed {
    logic signed [6:0] x;
    logic signed [6:0] y;
    logic [7:0]        cx;
    logic [7:0]        cy;
    logic [15:0]       color;
    logic              last;
  } point_t;

  // span phase within a point
  typedef enum logic [1:0] {
    PH_ROW_PY = 2'd0,
    PH_ROW_NY = 2'd1,
    PH_ROW_PX = 2'd2,
    PH_ROW_NX = 2'd3
  } phase_t;

endpackage

[sv/mcsf_front.sv]
`timescale 1ns / 1ps

module mcsf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [7:0]            req_cx,
  input  logic [7:0]            req_cy,
  input  logic [4:0]            req_radius,
  input  logic [15:0]           req_color,
  output logic                  pt_valid,
  input  logic                  pt_ready,
  output mcsf_pkg::point_t      pt
);
  import mcsf_pkg::*;

  logic               active;
  logic signed [6:0]  x;
  logic signed [6:0]  y;
  logic signed [10:0] d;
  logic [3:0]         count;
  logic [7:0]         cx;
  logic [7:0]         cy;
  logic [15:0]        color;

  logic [4:0]         r_clamp;
  logic               last_pt;
  logic signed [6:0]  x_next;
  logic signed [6:0]  y_next;
  logic signed [10:0] d_next;
  logic signed [10:0] x_ext;
  logic signed [10:0] y_ext;

  assign req_ready = !active;
  assign r_clamp   = (req_radius > MAX_RADIUS) ? MAX_RADIUS : req_radius;

  // loop test is on the point just emitted
  assign last_pt = (y < x) || (count == LAST_POINT_IDX);

  // decision walk step
  always_comb begin
    x_ext  = {{4{x[6]}}, x};
    y_ext  = {{4{y[6]}}, y};
    x_next = x + 7'sd1;
    if (d > 11'sd0) begin
      y_next = y - 7'sd1;
      d_next = d + ((x_ext - y_ext + 11'sd2) <<< 2) + 11'sd10;
    end else begin
      y_next = y;
      d_next = d + ((x_ext + 11'sd1) <<< 2) + 11'sd6;
    end
  end

  assign pt_valid = active;
  assign pt.x     = x;
  assign pt.y     = y;
  assign pt.cx    = cx;
  assign pt.cy    = cy;
  assign pt.color = color;
  assign pt.last  = last_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
    end else if (!active) begin
      if (req_valid) begin
        active <= 1'b1;
        count  <= '0;
        x      <= 7'sd0;
        y      <= signed'({2'b00, r_clamp});
        d      <= 11'sd3 - signed'({5'b0, r_clamp, 1'b0});
        cx     <= req_cx;
        cy     <= req_cy;
        color  <= req_color;
      end
    end else if (pt_ready) begin
      x     <= x_next;
      y     <= y_next;
      d     <= d_next;
      count <= count + 4'd1;
      if (last_pt) begin
        active <= 1'b0;
      end
    end
  end

endmodule

[sv/mcsf_queue.sv]
`timescale 1ns / 1ps

module mcsf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  mcsf_pkg::point_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output mcsf_pkg::point_t rd_data
);
  import mcsf_pkg::*;

  point_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     fill;
  logic                  do_wr;
  logic                  do_rd;

  assign wr_ready = (fill != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + (QUEUE_AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

[sv/mcsf_back.sv]
`timescale 1ns / 1ps

module mcsf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pt_valid,
  output logic             pt_ready,
  input  mcsf_pkg::point_t pt,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [9:0]       out_start,
  output logic [9:0]       out_end,
  output logic [9:0]       out_row,
  output logic [15:0]      out_color,
  output logic             out_last
);
  import mcsf_pkg::*;

  phase_t            phase;
  logic              load;
  logic signed [9:0] cx_s;
  logic signed [9:0] cy_s;
  logic signed [9:0] x_s;
  logic signed [9:0] y_s;
  logic signed [9:0] start_c;
  logic signed [9:0] end_c;
  logic signed [9:0] row_c;

  assign load     = pt_valid && (!out_valid || out_ready);
  assign pt_ready = load && (phase == PH_ROW_NX);

  // span of the current phase
  always_comb begin
    cx_s = signed'({2'b00, pt.cx});
    cy_s = signed'({2'b00, pt.cy});
    x_s  = {{3{pt.x[6]}}, pt.x};
    y_s  = {{3{pt.y[6]}}, pt.y};
    case (phase)
      PH_ROW_PY: begin
        start_c = cx_s - x_s;
        end_c   = cx_s + x_s;
        row_c   = cy_s + y_s;
      end
      PH_ROW_NY: begin
        start_c = cx_s - x_s;
        end_c   = cx_s + x_s;
        row_c   = cy_s - y_s;
      end
      PH_ROW_PX: begin
        start_c = cx_s - y_s;
        end_c   = cx_s + y_s;
        row_c   = cy_s + x_s;
      end
      default: begin
        start_c = cx_s - y_s;
        end_c   = cx_s + y_s;
        row_c   = cy_s - x_s;
      end
    endcase
  end

  // output register and phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_ROW_PY;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_start <= start_c;
        out_end   <= end_c;
        out_row   <= row_c;
        out_color <= pt.color;
        out_last  <= pt.last && (phase == PH_ROW_NX);
        phase     <= phase_t'(phase + 2'd1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/midpoint_circle_span_fill.sv]
`timescale 1ns / 1ps

// Filled circle span generator. Each input word is one circle request
// (center, radius, color); radii above 20 are clamped to 20. The block walks
// the Bresenham decision-variable circle and emits four horizontal spans
// (start column, end column, row, color) per walk point, unclipped and
// signed, with tlast on the final span of the circle. A circle yields
// 4 * P spans, P = number of walk points (at most 16), so at most 64 spans.
// The back end emits one span per cycle while m_tready is high and the queue
// holds a point; the front walker produces one point per cycle, while the
// four-entry point queue has room, and accepts the next request as soon as
// its own walk has finished, which lets the next circle's walk overlap the
// draining of the previous one. Output stalls back up through the queue.
module midpoint_circle_span_fill (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] center_x, [15:8] center_y, [20:16] radius, [36:21] fill_color
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [9:0] span_start, [19:10] span_end, [29:20] span_row, [45:30] span_color
  output logic [47:0] m_tdata,
  // last_span
  output logic        m_tlast
);
  import mcsf_pkg::*;

  logic   fq_valid;
  logic   fq_ready;
  point_t fq_data;
  logic   qb_valid;
  logic   qb_ready;
  point_t qb_data;
  logic [9:0]  span_start;
  logic [9:0]  span_end;
  logic [9:0]  span_row;
  logic [15:0] span_color;

  mcsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_cx     (s_tdata[7:0]),
    .req_cy     (s_tdata[15:8]),
    .req_radius (s_tdata[20:16]),
    .req_color  (s_tdata[36:21]),
    .pt_valid   (fq_valid),
    .pt_ready   (fq_ready),
    .pt         (fq_data)
  );

  mcsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  mcsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (qb_valid),
    .pt_ready  (qb_ready),
    .pt        (qb_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_start (span_start),
    .out_end   (span_end),
    .out_row   (span_row),
    .out_color (span_color),
    .out_last  (m_tlast)
  );

  assign m_tdata = {2'b00, span_color, span_row, span_end, span_start};

endmodule
